// ===== sv/fqd_pkg.sv =====
// types, command codes and controller/datapath interface structs for the queue
`timescale 1ns / 1ps
`default_nettype none
package fqd_pkg;

    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 5;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_DELETE  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0]          command;
        logic [HANDLE_W-1:0] handle;
    } in_item_t;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] removed_handle;
        logic [LEN_W-1:0]    length;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DEQ_OUT,
        ST_SCAN_WAIT,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;          // capture the input transfer, clear the walk offset
        logic rd_ahead;      // read one entry past the walk offset
        logic mem_wr;
        logic wr_tail;       // write the new handle at the tail, else shift down
        logic off_inc;
        logic cnt_inc;
        logic cnt_dec;
        logic head_adv;
        logic push;          // load the result register
        logic push_fail;
        logic push_removed;  // result carries the read entry as removed handle
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       handle_zero;
        logic       empty;
        logic       full;
        logic       match;
        logic       last;
        logic       out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/fqd_ctrl.sv =====
// sequencing state machine for enqueue, dequeue and delete-with-compaction
`timescale 1ns / 1ps
`default_nettype none
module fqd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fqd_pkg::dp_status_t stat,
    output fqd_pkg::ctrl_cmd_t      cmd
);

    fqd_pkg::state_t state_reg;
    fqd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fqd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            fqd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = fqd_pkg::ST_DECODE;
                end
            end
            fqd_pkg::ST_DECODE: begin
                case (stat.command)
                    fqd_pkg::CMD_ENQUEUE: begin
                        if (stat.out_free) begin
                            cmd.push = 1'b1;
                            if (!stat.handle_zero && !stat.full) begin
                                cmd.mem_wr  = 1'b1;
                                cmd.wr_tail = 1'b1;
                                cmd.cnt_inc = 1'b1;
                            end else begin
                                cmd.push_fail = 1'b1;
                            end
                            state_next = fqd_pkg::ST_IDLE;
                        end
                    end
                    fqd_pkg::CMD_DEQUEUE: begin
                        // head read is already in flight at offset zero
                        if (!stat.empty) begin
                            state_next = fqd_pkg::ST_DEQ_OUT;
                        end else if (stat.out_free) begin
                            cmd.push      = 1'b1;
                            cmd.push_fail = 1'b1;
                            state_next    = fqd_pkg::ST_IDLE;
                        end
                    end
                    fqd_pkg::CMD_DELETE: begin
                        if (!stat.handle_zero && !stat.empty) begin
                            state_next = fqd_pkg::ST_SCAN_CMP;
                        end else if (stat.out_free) begin
                            cmd.push      = 1'b1;
                            cmd.push_fail = 1'b1;
                            state_next    = fqd_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        if (stat.out_free) begin
                            cmd.push      = 1'b1;
                            cmd.push_fail = 1'b1;
                            state_next    = fqd_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            fqd_pkg::ST_DEQ_OUT: begin
                if (stat.out_free) begin
                    cmd.push         = 1'b1;
                    cmd.push_removed = 1'b1;
                    cmd.cnt_dec      = 1'b1;
                    cmd.head_adv     = 1'b1;
                    state_next       = fqd_pkg::ST_IDLE;
                end
            end
            fqd_pkg::ST_SCAN_CMP: begin
                if (stat.match) begin
                    state_next = fqd_pkg::ST_SHIFT_RD;
                end else if (stat.last) begin
                    if (stat.out_free) begin
                        cmd.push      = 1'b1;
                        cmd.push_fail = 1'b1;
                        state_next    = fqd_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.off_inc = 1'b1;
                    state_next  = fqd_pkg::ST_SCAN_WAIT;
                end
            end
            fqd_pkg::ST_SCAN_WAIT: begin
                state_next = fqd_pkg::ST_SCAN_CMP;
            end
            fqd_pkg::ST_SHIFT_RD: begin
                if (stat.last) begin
                    if (stat.out_free) begin
                        cmd.push    = 1'b1;
                        cmd.cnt_dec = 1'b1;
                        state_next  = fqd_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.rd_ahead = 1'b1;
                    state_next   = fqd_pkg::ST_SHIFT_WR;
                end
            end
            fqd_pkg::ST_SHIFT_WR: begin
                // successor entry is in the read register, move it down one slot
                cmd.rd_ahead = 1'b1;
                cmd.mem_wr   = 1'b1;
                cmd.off_inc  = 1'b1;
                state_next   = fqd_pkg::ST_SHIFT_RD;
            end
            default: begin
                state_next = fqd_pkg::ST_IDLE;
            end
        endcase
    end

    property p_push_has_room;
        @(posedge aclk) disable iff (!aresetn) cmd.push |-> stat.out_free;
    endproperty
    a_push_has_room: assert property (p_push_has_room)
        else $error("result pushed while the result register is still full");

    property p_load_from_idle;
        @(posedge aclk) disable iff (!aresetn) cmd.load |=> state_reg == fqd_pkg::ST_DECODE;
    endproperty
    a_load_from_idle: assert property (p_load_from_idle)
        else $error("captured transfer not followed by decode");

    property p_shift_write_after_read;
        @(posedge aclk) disable iff (!aresetn)
            state_reg == fqd_pkg::ST_SHIFT_WR |-> $past(state_reg) == fqd_pkg::ST_SHIFT_RD;
    endproperty
    a_shift_write_after_read: assert property (p_shift_write_after_read)
        else $error("shift write without a preceding read");

endmodule
`default_nettype wire

// ===== sv/fqd_datapath.sv =====
// entry memory, count/head registers, walk offset and result register
`timescale 1ns / 1ps
`default_nettype none
module fqd_datapath #(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire fqd_pkg::in_item_t   s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output fqd_pkg::out_item_t       m_payload,
    input  wire fqd_pkg::ctrl_cmd_t  cmd,
    output fqd_pkg::dp_status_t      stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    logic [HANDLE_WIDTH-1:0] entry_mem_reg [DEPTH];
    logic [HANDLE_WIDTH-1:0] rd_data_reg;

    logic [1:0]              command_reg;
    logic [HANDLE_WIDTH-1:0] handle_reg;
    logic [CW-1:0]           off_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [AW-1:0]           head_reg;
    logic [AW-1:0]           head_next;

    logic                    out_valid_reg;
    fqd_pkg::out_item_t      out_item_reg;

    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [CW:0]             rd_off;
    logic                    out_free;

    // circular position of an offset from head, sum stays below twice the depth
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW:0]   ofs);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(ofs);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_off  = (CW+1)'(off_reg) + (CW+1)'(cmd.rd_ahead);
    assign rd_addr = slot_of(head_reg, rd_off);
    assign wr_addr = cmd.wr_tail ? slot_of(head_reg, (CW+1)'(count_reg))
                                 : slot_of(head_reg, (CW+1)'(off_reg));

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            entry_mem_reg[wr_addr] <= cmd.wr_tail ? handle_reg : rd_data_reg;
        end
        rd_data_reg <= entry_mem_reg[rd_addr];
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
        head_next = head_reg;
        if (cmd.head_adv) begin
            head_next = slot_of(head_reg, (CW+1)'(1));
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
            if (cmd.push) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            command_reg <= s_payload.command;
            handle_reg  <= HANDLE_WIDTH'(s_payload.handle);
            off_reg     <= '0;
        end else if (cmd.off_inc) begin
            off_reg <= off_reg + CW'(1);
        end
        if (cmd.push) begin
            out_item_reg.status         <= cmd.push_fail ? fqd_pkg::STATUS_FAIL
                                                         : fqd_pkg::STATUS_OK;
            out_item_reg.removed_handle <= cmd.push_removed
                                         ? fqd_pkg::HANDLE_W'(rd_data_reg) : '0;
            out_item_reg.length         <= fqd_pkg::LEN_W'(count_next);
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

    always_comb begin
        stat             = '0;
        stat.command     = command_reg;
        stat.handle_zero = (handle_reg == '0);
        stat.empty       = (count_reg == '0);
        stat.full        = (count_reg == CW'(DEPTH));
        stat.match       = (rd_data_reg == handle_reg);
        stat.last        = ((CW+1)'(off_reg) + (CW+1)'(1) >= (CW+1)'(count_reg));
        stat.out_free    = out_free;
    end

    property p_count_bounded;
        @(posedge aclk) disable iff (!aresetn) count_reg <= CW'(DEPTH);
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("entry count above depth");

    property p_inc_dec_exclusive;
        @(posedge aclk) disable iff (!aresetn) !(cmd.cnt_inc && cmd.cnt_dec);
    endproperty
    a_inc_dec_exclusive: assert property (p_inc_dec_exclusive)
        else $error("count incremented and decremented together");

    property p_tail_write_not_full;
        @(posedge aclk) disable iff (!aresetn)
            (cmd.mem_wr && cmd.wr_tail) |-> (count_reg != CW'(DEPTH) && handle_reg != '0);
    endproperty
    a_tail_write_not_full: assert property (p_tail_write_not_full)
        else $error("tail write into a full queue or with a null handle");

    property p_dequeue_not_empty;
        @(posedge aclk) disable iff (!aresetn) cmd.head_adv |-> count_reg != '0;
    endproperty
    a_dequeue_not_empty: assert property (p_dequeue_not_empty)
        else $error("head advanced on an empty queue");

endmodule
`default_nettype wire

// ===== sv/fifo_queue_with_delete.sv =====
// top level of the ordered handle queue with delete-by-value
//
//   channel   valid     ready     payload
//   input     s_valid   s_ready   s_payload  (command, handle)
//   result    m_valid   m_ready   m_payload  (status, removed_handle, length)
//
// enqueue, an unused command and a null or empty-queue delete pass through decode
// alone; dequeue also passes through the output state unless the queue is empty
// delete walks the entry memory from the head, comparing entry after entry, and on a
// match moves every later entry down one slot with a read and a write step each
// synchronous active-low reset clears count, head and result valid; no memory clear
// input is taken while the previous result still waits; the walk stalls on its
// final transfer until the result register is free
`timescale 1ns / 1ps
`default_nettype none
module fifo_queue_with_delete #(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fqd_pkg::in_item_t  s_payload,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fqd_pkg::out_item_t      m_payload
);

    fqd_pkg::ctrl_cmd_t  cmd;
    fqd_pkg::dp_status_t stat;

    fqd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fqd_datapath #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the ordered handle queue with delete-by-value
`timescale 1ns / 1ps
module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int QUEUE_DEPTH  = 16;
    localparam int POOL_SIZE    = 12;
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 40;

    // predicts each command's result from its own copy of the queue contents
    class queue_scoreboard;
        logic [fqd_pkg::HANDLE_W-1:0] contents[$];
        fqd_pkg::out_item_t           due_results[$];
        int                           errors;

        task report_mismatch(string what);
            if (errors < MAX_PRINTS) begin
                $display("%0t ns: mismatch: %s", $realtime, what);
            end
            errors++;
        endtask

        function void note_command(fqd_pkg::in_item_t cmd);
            fqd_pkg::out_item_t res;
            int                 hit;
            int                 i;
            res.status         = fqd_pkg::STATUS_FAIL;
            res.removed_handle = '0;
            hit                = -1;
            case (cmd.command)
                fqd_pkg::CMD_ENQUEUE: begin
                    if (cmd.handle != '0 && contents.size() < QUEUE_DEPTH) begin
                        contents.push_back(cmd.handle);
                        res.status = fqd_pkg::STATUS_OK;
                    end
                end
                fqd_pkg::CMD_DEQUEUE: begin
                    if (contents.size() > 0) begin
                        res.removed_handle = contents.pop_front();
                        res.status         = fqd_pkg::STATUS_OK;
                    end
                end
                fqd_pkg::CMD_DELETE: begin
                    // first match from the head wins, the rest keep their order
                    if (cmd.handle != '0) begin
                        for (i = 0; i < contents.size() && hit < 0; i++) begin
                            if (contents[i] == cmd.handle) hit = i;
                        end
                        if (hit >= 0) begin
                            contents.delete(hit);
                            res.status = fqd_pkg::STATUS_OK;
                        end
                    end
                end
                default: begin
                end
            endcase
            res.length = fqd_pkg::LEN_W'(contents.size());
            due_results.push_back(res);
        endfunction

        task check_result(fqd_pkg::out_item_t got);
            fqd_pkg::out_item_t want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %p", got));
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
            end
            if (got.removed_handle !== want.removed_handle) begin
                report_mismatch($sformatf("removed_handle %h, expected %h",
                                          got.removed_handle, want.removed_handle));
            end
            if (got.length !== want.length) begin
                report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
            end
        endtask

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    fqd_pkg::in_item_t  s_payload;
    logic               m_valid;
    logic               m_ready;
    fqd_pkg::out_item_t m_payload;

    queue_scoreboard              sb = new();
    logic [fqd_pkg::HANDLE_W-1:0] handle_pool[POOL_SIZE];
    bit                           quiet;
    bit                           hold_req;
    int                           no_gap_left;

    fifo_queue_with_delete u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // both channels are sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_command(s_payload);
        if (aresetn && m_valid && m_ready) sb.check_result(m_payload);
    end

    // result side: random stalls, one long hold-off on request, none when quiet
    initial begin
        int n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (quiet) begin
                m_ready <= 1'b1;
                n = 1;
            end else if (hold_req) begin
                m_ready <= 1'b0;
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 6);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 10);
            end
            repeat (n) @(negedge aclk);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(logic [1:0] cmd, logic [fqd_pkg::HANDLE_W-1:0] h);
        fqd_pkg::in_item_t it;
        it.command = cmd;
        it.handle  = h;
        s_payload <= it;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic pause_sender(int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic issue(logic [1:0] cmd, logic [fqd_pkg::HANDLE_W-1:0] h);
        send_item(cmd, h);
        if (no_gap_left > 0) begin
            no_gap_left--;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            pause_sender($urandom_range(1, 6));
        end
    endtask

    // filling leans toward enqueue, draining toward dequeue and delete;
    // deletes mostly name a handle that is in the queue
    task automatic next_random_command(input bit filling, output logic [1:0] cmd,
                                       output logic [fqd_pkg::HANDLE_W-1:0] h);
        int roll;
        int pick;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            cmd = CMD_UNUSED;
        end else if (roll < (filling ? 60 : 30)) begin
            cmd = fqd_pkg::CMD_ENQUEUE;
        end else if (roll < (filling ? 78 : 70)) begin
            cmd = fqd_pkg::CMD_DEQUEUE;
        end else begin
            cmd = fqd_pkg::CMD_DELETE;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            h = '0;
        end else if (cmd == fqd_pkg::CMD_DELETE && sb.contents.size() > 0 && pick < 75) begin
            h = sb.contents[$urandom_range(0, sb.contents.size() - 1)];
        end else if (pick < 80) begin
            h = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            h = $urandom;
        end
    endtask

    initial begin
        logic [1:0]                   cmd;
        logic [fqd_pkg::HANDLE_W-1:0] h;
        bit                           filling;
        int                           k;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_payload   = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        no_gap_left = 0;
        filling     = 1'b1;
        for (k = 0; k < POOL_SIZE; k++) handle_pool[k] = $urandom | 32'd1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // rejected commands on an empty queue
        issue(fqd_pkg::CMD_DEQUEUE, 32'h0);
        issue(fqd_pkg::CMD_DELETE, 32'h5);
        issue(CMD_UNUSED, 32'hFFFF_FFFF);
        issue(fqd_pkg::CMD_ENQUEUE, 32'h0);
        issue(fqd_pkg::CMD_DELETE, 32'h0);
        // duplicate handle: delete takes the one nearer the head
        issue(fqd_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
        issue(fqd_pkg::CMD_ENQUEUE, 32'h1);
        issue(fqd_pkg::CMD_ENQUEUE, 32'h8000_0000);
        issue(fqd_pkg::CMD_ENQUEUE, 32'h1);
        issue(fqd_pkg::CMD_DELETE, 32'h1);
        issue(fqd_pkg::CMD_DELETE, 32'h77);
        issue(fqd_pkg::CMD_DEQUEUE, 32'h0);
        // fill up with the store wrapped, then enqueue on a full queue
        for (k = 0; k < QUEUE_DEPTH - 2; k++) begin
            issue(fqd_pkg::CMD_ENQUEUE, 32'h1111 * (k + 2));
        end
        issue(fqd_pkg::CMD_ENQUEUE, 32'hA5A5_5A5A);
        issue(fqd_pkg::CMD_DELETE, 32'h1111 * (QUEUE_DEPTH - 1));
        issue(fqd_pkg::CMD_DELETE, 32'h8000_0000);
        issue(fqd_pkg::CMD_DEQUEUE, 32'h0);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 64 == 0) filling = $urandom_range(0, 1);
            if (k == 300) begin
                // long receiver hold-off with the sender pushing back to back
                hold_req    = 1'b1;
                no_gap_left = 40;
            end
            if (k == 700) begin
                pause_sender(1);
                while (sb.pending() != 0) @(negedge aclk);
            end
            if (k == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            next_random_command(filling, cmd, h);
            issue(cmd, h);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== fifo_queue_with_delete.f =====
sv/fqd_pkg.sv
sv/fqd_ctrl.sv
sv/fqd_datapath.sv
sv/fifo_queue_with_delete.sv
verif/testbench.sv
